FILE: hw/rtl/tlca_pkg.sv
package tlca_pkg;

    localparam int MAX_NODES_DEF  = 1024;
    localparam int LOG_LEVELS_DEF = 10;

    localparam int NODE_W  = 10;
    localparam int DIST_W  = 11;
    localparam int DEPTH_W = 11;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

    // Codes of the action field.
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        logic              action;
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] partner;
    } req_t;

    typedef struct packed {
        logic [NODE_W-1:0] common_ancestor;
        logic [DIST_W-1:0] distance;
    } resp_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LD_RD,
        S_LD_WR,
        S_LV_RD,
        S_LV_WR,
        S_Q_DA,
        S_Q_DB,
        S_Q_ORD,
        S_P1_ANC,
        S_P1_DEP,
        S_P1_LAST,
        S_P1_CHK,
        S_P2_RD,
        S_P2_CMP,
        S_P2_PAR,
        S_P2_GET,
        S_DL_RD,
        S_DL_OUT
    } state_t;

    // Address source of the depth memory read port.
    typedef enum logic [1:0] {
        DSEL_A,
        DSEL_B,
        DSEL_UP,
        DSEL_L
    } dsel_t;

    // Node source of the first ancestor memory read port.
    typedef enum logic [1:0] {
        ASEL_A,
        ASEL_B,
        ASEL_LIFT
    } asel_t;

    typedef struct packed {
        logic  capture;
        dsel_t dsel;
        asel_t asel;
        logic  wr_base;
        logic  wr_level;
        logic  da_capture;
        logic  order;
        logic  lift;
        logic  note_up;
        logic  step2;
        logic  l_from_a;
        logic  l_from_qa;
        logic  emit;
    } cmd_t;

    typedef struct packed {
        logic a_zero;
        logic a_eq_b;
        logic out_free;
    } status_t;

endpackage

FILE: hw/rtl/tree_lca_distance_top.sv
// Lowest common ancestor and tree distance over a binary-lifting ancestor table.
// Input channel req (req_valid, req_stall, req_item): action 0 loads node with
// its parent in partner (0 for a root), parents before children; action 1
// queries node and partner. Output channel resp (resp_valid, resp_stall,
// resp_item) carries one item per query: common ancestor and edge distance.
// An item is accepted while the sequencer is idle. A load to node 0 is dropped;
// any other load writes the parent and depth, then one ancestor level at a time.
// A query lifts the deeper node to equal depth and, unless that lift already
// meets the other node, lifts both nodes jointly and takes the parent; it then
// reads the ancestor's depth, and a result shows on resp the cycle after it is
// emitted. The sequence is set by the chain of dependent reads through the
// ancestor and depth memories, one lifting level after another. The result
// register lets the next item be accepted while a result waits; a query that
// finishes while resp is still stalled holds until the waiting item is taken.
// Reset clears the sequencer and resp_valid; the tables need no clearing,
// since the sentinel row and depth read as zero by address.
module tree_lca_distance_top #(
    parameter int MAX_NODES  = tlca_pkg::MAX_NODES_DEF,
    parameter int LOG_LEVELS = tlca_pkg::LOG_LEVELS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  tlca_pkg::req_t   req_item,
    output logic             resp_valid,
    input  logic             resp_stall,
    output tlca_pkg::resp_t  resp_item
);

    localparam int LVL_W = $clog2(LOG_LEVELS + 1);

    tlca_pkg::cmd_t     cmd;
    tlca_pkg::status_t  status;
    logic [LVL_W-1:0]   level;

    tlca_ctrl #(
        .LOG_LEVELS (LOG_LEVELS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .action    (req_item.action),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd),
        .level     (level)
    );

    tlca_datapath #(
        .MAX_NODES  (MAX_NODES),
        .LOG_LEVELS (LOG_LEVELS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_item   (req_item),
        .cmd        (cmd),
        .level      (level),
        .status     (status),
        .resp_valid (resp_valid),
        .resp_stall (resp_stall),
        .resp_item  (resp_item)
    );

endmodule

FILE: hw/rtl/tlca_ctrl.sv
module tlca_ctrl #(
    parameter int LOG_LEVELS = tlca_pkg::LOG_LEVELS_DEF,
    localparam int LVL_W = $clog2(LOG_LEVELS + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic               action,
    output logic               req_stall,
    input  tlca_pkg::status_t  status,
    output tlca_pkg::cmd_t     cmd,
    output logic [LVL_W-1:0]   level
);

    localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(LOG_LEVELS);
    localparam logic [LVL_W-1:0] LVL_ONE = LVL_W'(1);

    tlca_pkg::state_t  state_reg;
    tlca_pkg::state_t  state_next;
    logic [LVL_W-1:0]  lvl_reg;
    logic [LVL_W-1:0]  lvl_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tlca_pkg::S_IDLE;
            lvl_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            lvl_reg   <= lvl_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        lvl_next       = lvl_reg;
        level          = lvl_reg;
        req_stall      = 1'b1;
        cmd.capture    = 1'b0;
        cmd.dsel       = tlca_pkg::DSEL_B;
        cmd.asel       = tlca_pkg::ASEL_A;
        cmd.wr_base    = 1'b0;
        cmd.wr_level   = 1'b0;
        cmd.da_capture = 1'b0;
        cmd.order      = 1'b0;
        cmd.lift       = 1'b0;
        cmd.note_up    = 1'b0;
        cmd.step2      = 1'b0;
        cmd.l_from_a   = 1'b0;
        cmd.l_from_qa  = 1'b0;
        cmd.emit       = 1'b0;

        case (state_reg)
            tlca_pkg::S_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = (action == tlca_pkg::ACT_QUERY) ? tlca_pkg::S_Q_DA
                                                                  : tlca_pkg::S_LD_RD;
                end
            end
            tlca_pkg::S_LD_RD:
            begin
                // A load to the sentinel node is dropped here.
                cmd.dsel   = tlca_pkg::DSEL_B;
                state_next = status.a_zero ? tlca_pkg::S_IDLE : tlca_pkg::S_LD_WR;
            end
            tlca_pkg::S_LD_WR:
            begin
                cmd.wr_base = 1'b1;
                level       = '0;
                lvl_next    = LVL_ONE;
                state_next  = tlca_pkg::S_LV_RD;
            end
            tlca_pkg::S_LV_RD:
            begin
                cmd.asel   = tlca_pkg::ASEL_B;
                level      = lvl_reg - LVL_ONE;
                state_next = tlca_pkg::S_LV_WR;
            end
            tlca_pkg::S_LV_WR:
            begin
                cmd.wr_level = 1'b1;
                if (lvl_reg == LVL_TOP)
                begin
                    state_next = tlca_pkg::S_IDLE;
                end
                else
                begin
                    lvl_next   = lvl_reg + LVL_ONE;
                    state_next = tlca_pkg::S_LV_RD;
                end
            end
            tlca_pkg::S_Q_DA:
            begin
                cmd.dsel   = tlca_pkg::DSEL_A;
                state_next = tlca_pkg::S_Q_DB;
            end
            tlca_pkg::S_Q_DB:
            begin
                cmd.da_capture = 1'b1;
                cmd.dsel       = tlca_pkg::DSEL_B;
                state_next     = tlca_pkg::S_Q_ORD;
            end
            tlca_pkg::S_Q_ORD:
            begin
                cmd.order  = 1'b1;
                lvl_next   = LVL_TOP;
                state_next = tlca_pkg::S_P1_ANC;
            end
            tlca_pkg::S_P1_ANC:
            begin
                // Apply the previous level's decision and read the next jump from there.
                cmd.lift   = 1'b1;
                cmd.asel   = tlca_pkg::ASEL_LIFT;
                state_next = tlca_pkg::S_P1_DEP;
            end
            tlca_pkg::S_P1_DEP:
            begin
                cmd.note_up = 1'b1;
                cmd.dsel    = tlca_pkg::DSEL_UP;
                if (lvl_reg == '0)
                begin
                    state_next = tlca_pkg::S_P1_LAST;
                end
                else
                begin
                    lvl_next   = lvl_reg - LVL_ONE;
                    state_next = tlca_pkg::S_P1_ANC;
                end
            end
            tlca_pkg::S_P1_LAST:
            begin
                cmd.lift   = 1'b1;
                state_next = tlca_pkg::S_P1_CHK;
            end
            tlca_pkg::S_P1_CHK:
            begin
                if (status.a_eq_b)
                begin
                    cmd.l_from_a = 1'b1;
                    state_next   = tlca_pkg::S_DL_RD;
                end
                else
                begin
                    lvl_next   = LVL_TOP;
                    state_next = tlca_pkg::S_P2_RD;
                end
            end
            tlca_pkg::S_P2_RD:
            begin
                cmd.asel   = tlca_pkg::ASEL_A;
                state_next = tlca_pkg::S_P2_CMP;
            end
            tlca_pkg::S_P2_CMP:
            begin
                cmd.step2 = 1'b1;
                if (lvl_reg == '0)
                begin
                    state_next = tlca_pkg::S_P2_PAR;
                end
                else
                begin
                    lvl_next   = lvl_reg - LVL_ONE;
                    state_next = tlca_pkg::S_P2_RD;
                end
            end
            tlca_pkg::S_P2_PAR:
            begin
                cmd.asel   = tlca_pkg::ASEL_A;
                level      = '0;
                state_next = tlca_pkg::S_P2_GET;
            end
            tlca_pkg::S_P2_GET:
            begin
                cmd.l_from_qa = 1'b1;
                state_next    = tlca_pkg::S_DL_RD;
            end
            tlca_pkg::S_DL_RD:
            begin
                cmd.dsel   = tlca_pkg::DSEL_L;
                state_next = tlca_pkg::S_DL_OUT;
            end
            tlca_pkg::S_DL_OUT:
            begin
                // The read address is held so the depth stays put while the output is full.
                cmd.dsel = tlca_pkg::DSEL_L;
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = tlca_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = tlca_pkg::S_IDLE;
            end
        endcase
    end

    a_accept_starts_work: assert property (
        @(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg != tlca_pkg::S_IDLE)
    ) else $error("accepted item did not start a sequence");

    a_level_in_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        lvl_reg <= LVL_TOP
    ) else $error("level counter beyond the top level");

    a_pass2_descends: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == tlca_pkg::S_P2_CMP && lvl_reg != '0)
            |=> (lvl_reg == $past(lvl_reg) - LVL_ONE)
    ) else $error("joint lift did not step down one level");

endmodule

FILE: hw/rtl/tlca_datapath.sv
module tlca_datapath #(
    parameter int MAX_NODES  = tlca_pkg::MAX_NODES_DEF,
    parameter int LOG_LEVELS = tlca_pkg::LOG_LEVELS_DEF,
    localparam int LVL_W = $clog2(LOG_LEVELS + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  tlca_pkg::req_t     req_item,
    input  tlca_pkg::cmd_t     cmd,
    input  logic [LVL_W-1:0]   level,
    output tlca_pkg::status_t  status,
    output logic               resp_valid,
    input  logic               resp_stall,
    output tlca_pkg::resp_t    resp_item
);

    localparam int NODE_W    = tlca_pkg::NODE_W;
    localparam int DIST_W    = tlca_pkg::DIST_W;
    localparam int DEPTH_W   = tlca_pkg::DEPTH_W;
    localparam int SUM_W     = DEPTH_W + 1;
    localparam int DIFF_W    = DEPTH_W + 2;
    localparam int IDX_W     = $clog2(MAX_NODES);
    localparam int ANC_AW    = IDX_W + LVL_W;
    localparam int ANC_DEPTH = MAX_NODES * (2 ** LVL_W);

    // Ancestor table: row per node, one entry per doubling level.
    logic [IDX_W-1:0]   anc_mem [ANC_DEPTH];
    logic [DEPTH_W-1:0] depth_mem [MAX_NODES];

    logic [IDX_W-1:0]   node_idx;
    logic [IDX_W-1:0]   partner_idx;

    logic [IDX_W-1:0]   a_reg;
    logic [IDX_W-1:0]   b_reg;
    logic [IDX_W-1:0]   up_reg;
    logic [IDX_W-1:0]   l_reg;
    logic [DEPTH_W-1:0] da_reg;
    logic [DEPTH_W-1:0] db_reg;
    logic [SUM_W-1:0]   sum_reg;

    logic [IDX_W-1:0]   anc_qa_reg;
    logic [IDX_W-1:0]   anc_qb_reg;
    logic               za_reg;
    logic               zb_reg;
    logic [DEPTH_W-1:0] depth_q_reg;
    logic               zd_reg;

    logic [IDX_W-1:0]   anc_qa;
    logic [IDX_W-1:0]   anc_qb;
    logic [DEPTH_W-1:0] dep_rd;
    logic [IDX_W-1:0]   a_eff;
    logic [IDX_W-1:0]   node_a_sel;
    logic [ANC_AW-1:0]  anc_ra_a;
    logic [ANC_AW-1:0]  anc_ra_b;
    logic [ANC_AW-1:0]  anc_wa;
    logic [IDX_W-1:0]   anc_wd;
    logic               anc_we;
    logic [IDX_W-1:0]   depth_ra;
    logic [DEPTH_W-1:0] depth_wd;

    logic signed [DIFF_W-1:0] diff;
    logic [DIST_W-1:0]        dist_sat;

    logic                     resp_valid_reg;
    logic                     resp_valid_next;
    tlca_pkg::resp_t          resp_reg;
    tlca_pkg::resp_t          resp_next;
    logic                     out_free;

    // Node numbers past the table size stand for the sentinel.
    assign node_idx    = (32'(req_item.node) < 32'(MAX_NODES)) ? IDX_W'(req_item.node) : '0;
    assign partner_idx = (32'(req_item.partner) < 32'(MAX_NODES)) ? IDX_W'(req_item.partner) : '0;

    // The sentinel row is never written, so its reads are forced to zero.
    assign anc_qa = za_reg ? '0 : anc_qa_reg;
    assign anc_qb = zb_reg ? '0 : anc_qb_reg;
    assign dep_rd = zd_reg ? '0 : depth_q_reg;

    assign a_eff = (dep_rd >= db_reg) ? up_reg : a_reg;

    always_comb
    begin
        case (cmd.asel)
            tlca_pkg::ASEL_A:    node_a_sel = a_reg;
            tlca_pkg::ASEL_B:    node_a_sel = b_reg;
            tlca_pkg::ASEL_LIFT: node_a_sel = a_eff;
            default:             node_a_sel = a_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.dsel)
            tlca_pkg::DSEL_A:  depth_ra = a_reg;
            tlca_pkg::DSEL_B:  depth_ra = b_reg;
            tlca_pkg::DSEL_UP: depth_ra = anc_qa;
            tlca_pkg::DSEL_L:  depth_ra = l_reg;
            default:           depth_ra = b_reg;
        endcase
    end

    assign anc_ra_a = {node_a_sel, level};
    assign anc_ra_b = {b_reg, level};
    assign anc_we   = cmd.wr_base | cmd.wr_level;
    assign anc_wa   = {a_reg, level};
    assign anc_wd   = cmd.wr_base ? b_reg : anc_qa;
    assign depth_wd = (dep_rd == tlca_pkg::DEPTH_MAX) ? tlca_pkg::DEPTH_MAX
                                                      : dep_rd + DEPTH_W'(1);

    always_ff @(posedge clk)
    begin
        if (anc_we)
        begin
            anc_mem[anc_wa] <= anc_wd;
        end
        anc_qa_reg <= anc_mem[anc_ra_a];
        anc_qb_reg <= anc_mem[anc_ra_b];
        za_reg     <= (node_a_sel == '0);
        zb_reg     <= (b_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_base)
        begin
            depth_mem[a_reg] <= depth_wd;
        end
        depth_q_reg <= depth_mem[depth_ra];
        zd_reg      <= (depth_ra == '0);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            a_reg <= node_idx;
            b_reg <= partner_idx;
        end
        if (cmd.da_capture)
        begin
            da_reg <= dep_rd;
        end
        if (cmd.order)
        begin
            sum_reg <= SUM_W'(da_reg) + SUM_W'(dep_rd);
            // The deeper node goes to a; up starts equal to a so the first lift is a no-op.
            if (da_reg < dep_rd)
            begin
                a_reg  <= b_reg;
                b_reg  <= a_reg;
                up_reg <= b_reg;
                db_reg <= da_reg;
            end
            else
            begin
                up_reg <= a_reg;
                db_reg <= dep_rd;
            end
        end
        if (cmd.lift)
        begin
            a_reg <= a_eff;
        end
        if (cmd.note_up)
        begin
            up_reg <= anc_qa;
        end
        if (cmd.wr_level)
        begin
            b_reg <= anc_qa;
        end
        if (cmd.step2 && (anc_qa != anc_qb))
        begin
            a_reg <= anc_qa;
            b_reg <= anc_qb;
        end
        if (cmd.l_from_a)
        begin
            l_reg <= a_reg;
        end
        if (cmd.l_from_qa)
        begin
            l_reg <= anc_qa;
        end
    end

    // Distance is depth(a) + depth(b) - 2 * depth(lca), clamped to the field range.
    assign diff = $signed({1'b0, sum_reg}) - $signed({1'b0, dep_rd, 1'b0});

    always_comb
    begin
        if (diff[DIFF_W-1])
        begin
            dist_sat = '0;
        end
        else if (diff[DIFF_W-2:DIST_W] != '0)
        begin
            dist_sat = '1;
        end
        else
        begin
            dist_sat = diff[DIST_W-1:0];
        end
    end

    assign out_free = !resp_valid_reg || !resp_stall;

    always_comb
    begin
        resp_next.common_ancestor = NODE_W'(l_reg);
        resp_next.distance        = dist_sat;
        if (cmd.emit)
        begin
            resp_valid_next = 1'b1;
        end
        else if (!resp_stall)
        begin
            resp_valid_next = 1'b0;
        end
        else
        begin
            resp_valid_next = resp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resp_valid_reg <= 1'b0;
        end
        else
        begin
            resp_valid_reg <= resp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            resp_reg <= resp_next;
        end
    end

    assign resp_valid      = resp_valid_reg;
    assign resp_item       = resp_reg;
    assign status.a_zero   = (a_reg == '0);
    assign status.a_eq_b   = (a_reg == b_reg);
    assign status.out_free = out_free;

    a_sentinel_untouched: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.wr_base |-> (a_reg != '0)
    ) else $error("write aimed at the sentinel row");

    a_emit_only_when_free: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!resp_valid_reg || !resp_stall)
    ) else $error("result overwrote an item not yet taken");

endmodule

FILE: bench/tree_lca_distance_top_tb.sv
`timescale 1ns / 100ps

module tree_lca_distance_top_tb;

    localparam int NODES        = tlca_pkg::MAX_NODES_DEF;
    localparam int LEVEL_TOP    = tlca_pkg::LOG_LEVELS_DEF;
    localparam int DIR_ROWS     = 22;
    localparam int RANDOM_ITEMS = 1620;
    localparam int DRAIN_CYCLES = 80;

    typedef logic [tlca_pkg::NODE_W-1:0] node_t;

    typedef struct packed {
        logic                        action;
        node_t                       node;
        node_t                       partner;
        logic                        typed;
        node_t                       lca;
        logic [tlca_pkg::DIST_W-1:0] edges;
    } stim_row_t;

    // Rows marked typed carry a result that follows directly from the tree built so far.
    stim_row_t dir_rows [DIR_ROWS] = '{
        '{tlca_pkg::ACT_QUERY, 10'd0,    10'd0,    1'b1, 10'd0,    11'd0},
        '{tlca_pkg::ACT_LOAD,  10'd1023, 10'd0,    1'b0, 10'd0,    11'd0},
        '{tlca_pkg::ACT_LOAD,  10'd1,    10'd1023, 1'b0, 10'd0,    11'd0},
        '{tlca_pkg::ACT_LOAD,  10'd512,  10'd1,    1'b0, 10'd0,    11'd0},
        '{tlca_pkg::ACT_LOAD,  10'd2,    10'd1023, 1'b0, 10'd0,    11'd0},
        '{tlca_pkg::ACT_LOAD,  10'd1022, 10'd2,    1'b0, 10'd0,    11'd0},
        '{tlca_pkg::ACT_QUERY, 10'd1023, 10'd1023, 1'b1, 10'd1023, 11'd0},
        '{tlca_pkg::ACT_QUERY, 10'd0,    10'd1023, 1'b1, 10'd0,    11'd1},
        '{tlca_pkg::ACT_QUERY, 10'd512,  10'd1022, 1'b1, 10'd1023, 11'd4},
        '{tlca_pkg::ACT_QUERY, 10'd1,    10'd512,  1'b1, 10'd1,    11'd1},
        '{tlca_pkg::ACT_QUERY, 10'd512,  10'd1,    1'b1, 10'd1,    11'd1},
        '{tlca_pkg::ACT_LOAD,  10'd0,    10'd1,    1'b0, 10'd0,    11'd0},
        '{tlca_pkg::ACT_QUERY, 10'd0,    10'd0,    1'b1, 10'd0,    11'd0},
        '{tlca_pkg::ACT_LOAD,  10'd341,  10'd0,    1'b0, 10'd0,    11'd0},
        '{tlca_pkg::ACT_LOAD,  10'd682,  10'd341,  1'b0, 10'd0,    11'd0},
        '{tlca_pkg::ACT_QUERY, 10'd682,  10'd1022, 1'b1, 10'd0,    11'd5},
        '{tlca_pkg::ACT_QUERY, 10'd682,  10'd341,  1'b1, 10'd341,  11'd1},
        '{tlca_pkg::ACT_LOAD,  10'd2,    10'd512,  1'b0, 10'd0,    11'd0},
        '{tlca_pkg::ACT_QUERY, 10'd1022, 10'd512,  1'b0, 10'd0,    11'd0},
        '{tlca_pkg::ACT_LOAD,  10'd1023, 10'd1023, 1'b0, 10'd0,    11'd0},
        '{tlca_pkg::ACT_QUERY, 10'd512,  10'd682,  1'b0, 10'd0,    11'd0},
        '{tlca_pkg::ACT_QUERY, 10'd1022, 10'd0,    1'b0, 10'd0,    11'd0}
    };

    logic            clk;
    logic            rst_n;
    logic            req_valid;
    logic            req_stall;
    tlca_pkg::req_t  req_item;
    logic            resp_valid;
    logic            resp_stall;
    tlca_pkg::resp_t resp_item;

    node_t                        lift_table  [NODES][LEVEL_TOP+1];
    logic [tlca_pkg::DEPTH_W-1:0] depth_of    [NODES];
    bit                           node_loaded [NODES];
    node_t                        loaded_q    [$];
    tlca_pkg::resp_t              expected_q  [$];

    int send_idle_pct = 28;
    int recv_idle_pct = 57;
    int errors        = 0;
    int loads_sent    = 0;
    int queries_sent  = 0;
    int results_seen  = 0;

    tree_lca_distance_top i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_item   (req_item),
        .resp_valid (resp_valid),
        .resp_stall (resp_stall),
        .resp_item  (resp_item)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #15_000_000;
        $display("Timeout with %0d results still pending.", expected_q.size());
        $display("tree_lca_distance_top_tb: errors");
        $finish;
    end

    task automatic report_mismatch(string what, int got, int want);
        if (errors < 50)
            $display("%0t mismatch in %s: got %0d, want %0d", $time, what, got, want);
        errors++;
    endtask

    // Stores parent and depth, then fills each doubling level from the rows already there.
    function automatic void load_node(node_t n, node_t p);
        logic [tlca_pkg::DEPTH_W:0] d;
        if (n == '0)
            return;
        d = {1'b0, depth_of[p]} + 1'b1;
        depth_of[n] = (d > tlca_pkg::DEPTH_MAX) ? tlca_pkg::DEPTH_MAX
                                                : d[tlca_pkg::DEPTH_W-1:0];
        lift_table[n][0] = p;
        for (int i = 1; i <= LEVEL_TOP; i++)
            lift_table[n][i] = lift_table[lift_table[n][i-1]][i-1];
        if (!node_loaded[n])
        begin
            node_loaded[n] = 1'b1;
            loaded_q.insert(loaded_q.size(), n);
        end
    endfunction

    function automatic tlca_pkg::resp_t common_ancestor_of(node_t a, node_t b);
        node_t           hi;
        node_t           lo;
        node_t           t;
        node_t           ua;
        node_t           ub;
        int              hops;
        tlca_pkg::resp_t res;
        hi = a;
        lo = b;
        if (depth_of[hi] < depth_of[lo])
        begin
            t  = hi;
            hi = lo;
            lo = t;
        end
        for (int i = LEVEL_TOP; i >= 0; i--)
        begin
            ua = lift_table[hi][i];
            if (depth_of[ua] >= depth_of[lo])
                hi = ua;
        end
        if (hi != lo)
        begin
            for (int i = LEVEL_TOP; i >= 0; i--)
            begin
                ua = lift_table[hi][i];
                ub = lift_table[lo][i];
                if (ua != ub)
                begin
                    hi = ua;
                    lo = ub;
                end
            end
            hi = lift_table[hi][0];
        end
        hops = int'(depth_of[a]) + int'(depth_of[b]) - 2 * int'(depth_of[hi]);
        if (hops < 0)
            hops = 0;
        if (hops > int'(tlca_pkg::DEPTH_MAX))
            hops = int'(tlca_pkg::DEPTH_MAX);
        res.common_ancestor = hi;
        res.distance        = hops[tlca_pkg::DIST_W-1:0];
        return res;
    endfunction

    task automatic hand_over(tlca_pkg::req_t item);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req_item  <= item;
        do
            @(posedge clk);
        while (req_stall);
    endtask

    task automatic issue_item(tlca_pkg::req_t item, bit typed, tlca_pkg::resp_t typed_resp);
        hand_over(item);
        if (item.action == tlca_pkg::ACT_LOAD)
        begin
            load_node(item.node, item.partner);
            loads_sent++;
        end
        else
        begin
            expected_q.insert(expected_q.size(),
                              typed ? typed_resp : common_ancestor_of(item.node, item.partner));
            queries_sent++;
        end
    endtask

    always @(negedge clk)
        resp_stall <= ($urandom_range(99) < recv_idle_pct);

    always @(posedge clk)
    begin : resp_check
        tlca_pkg::resp_t want;
        if (rst_n && resp_valid && !resp_stall)
        begin
            results_seen++;
            if (expected_q.size() == 0)
                report_mismatch("unexpected result, ancestor", resp_item.common_ancestor, -1);
            else
            begin
                want = expected_q.pop_front();
                if (resp_item.common_ancestor !== want.common_ancestor)
                    report_mismatch("common_ancestor", resp_item.common_ancestor,
                                    want.common_ancestor);
                if (resp_item.distance !== want.distance)
                    report_mismatch("distance", resp_item.distance, want.distance);
            end
        end
    end

    initial
    begin
        tlca_pkg::req_t  item;
        tlca_pkg::resp_t want;
        node_t           n;
        node_t           p;
        int              roll;
        int              sel;
        int              span;

        rst_n      = 1'b0;
        req_valid  = 1'b0;
        req_item   = '0;
        for (int k = 0; k < NODES; k++)
        begin
            depth_of[k]    = '0;
            node_loaded[k] = 1'b0;
            for (int i = 0; i <= LEVEL_TOP; i++)
                lift_table[k][i] = '0;
        end
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++)
        begin
            item.action          = dir_rows[r].action;
            item.node            = dir_rows[r].node;
            item.partner         = dir_rows[r].partner;
            want.common_ancestor = dir_rows[r].lca;
            want.distance        = dir_rows[r].edges;
            issue_item(item, dir_rows[r].typed, want);
        end

        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k == RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 57;
                recv_idle_pct = 28;
            end
            else if (k == 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            roll        = $urandom_range(99);
            item.action = tlca_pkg::ACT_LOAD;
            if (roll < 42 && loaded_q.size() < NODES - 1)
            begin
                // Fresh nodes mostly hang under recent ones, so chains grow deep.
                do
                    n = node_t'($urandom_range(NODES - 1, 1));
                while (node_loaded[n]);
                sel  = $urandom_range(99);
                span = (loaded_q.size() > 8) ? 7 : loaded_q.size() - 1;
                if (sel < 12)
                    p = '0;
                else if (sel < 70)
                    p = loaded_q[loaded_q.size() - 1 - $urandom_range(span)];
                else
                    p = loaded_q[$urandom_range(loaded_q.size() - 1)];
            end
            else if (roll < 47)
            begin
                // A reload may put a node under itself or a descendant.
                n = loaded_q[$urandom_range(loaded_q.size() - 1)];
                p = loaded_q[$urandom_range(loaded_q.size() - 1)];
            end
            else if (roll < 50)
            begin
                n = '0;
                p = loaded_q[$urandom_range(loaded_q.size() - 1)];
            end
            else
            begin
                item.action = tlca_pkg::ACT_QUERY;
                n = ($urandom_range(19) == 0) ? '0
                                               : loaded_q[$urandom_range(loaded_q.size() - 1)];
                p = ($urandom_range(19) == 0) ? '0
                                               : loaded_q[$urandom_range(loaded_q.size() - 1)];
            end
            item.node    = n;
            item.partner = p;
            issue_item(item, 1'b0, '0);
        end

        @(negedge clk);
        req_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d loads and %0d queries over %0d tree nodes; %0d results compared.",
                 loads_sent, queries_sent, loaded_q.size(), results_seen);
        $display("Trees included reloads under descendants; %0d mismatches.", errors);
        if (errors == 0)
            $display("tree_lca_distance_top_tb: clean");
        else
            $display("tree_lca_distance_top_tb: errors");
        $finish;
    end

endmodule
